>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the conversion modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/itoa_pkg.sv
package itoa_pkg;

    // Input magnitude and decimal digit store
    localparam int MAG_W      = 32;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int BITCNT_W   = $clog2(MAG_W);
    localparam int DIGCNT_W   = $clog2(NUM_DIGITS + 1);
    localparam int CHAR_W     = 6;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 6'd57;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic conv_step;
        logic skip_step;
        logic emit_sign;
        logic emit_digit;
    } itoa_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic conv_done;
        logic lead_zero;
        logic negative;
        logic last_digit;
        logic out_free;
    } itoa_sts_t;

endpackage

>>> rtl/core/itoa_dp.sv
`include "assert_macros.svh"

module itoa_dp
    import itoa_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic signed [MAG_W-1:0]  value,
    input  itoa_cmd_t                cmd,
    output itoa_sts_t                sts,
    input  logic                     out_ready,
    output logic                     out_valid,
    output logic [CHAR_W-1:0]        char_code,
    output logic                     is_last
);

    logic [MAG_W-1:0]    mag_reg, mag_next;
    logic [BCD_W-1:0]    bcd_reg, bcd_next;
    logic [BCD_W-1:0]    bcd_adj;
    logic                neg_reg, neg_next;
    logic [BITCNT_W-1:0] bitcnt_reg, bitcnt_next;
    logic [DIGCNT_W-1:0] digits_left_reg, digits_left_next;
    logic                out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]   char_code_reg, char_code_next;
    logic                is_last_reg, is_last_next;
    logic [MAG_W-1:0]    value_u;
    logic [3:0]          top_digit;

    assign value_u   = MAG_W'(value);
    assign top_digit = bcd_reg[BCD_W-1 -: 4];

    // Double dabble: add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        bcd_adj = bcd_reg;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
        end
    end

    // Conversion registers
    always_comb
    begin
        mag_next         = mag_reg;
        bcd_next         = bcd_reg;
        neg_next         = neg_reg;
        bitcnt_next      = bitcnt_reg;
        digits_left_next = digits_left_reg;
        if (cmd.load)
        begin
            neg_next         = value_u[MAG_W-1];
            mag_next         = value_u[MAG_W-1] ? (~value_u + 1'b1) : value_u;
            bcd_next         = '0;
            bitcnt_next      = '0;
            digits_left_next = DIGCNT_W'(NUM_DIGITS);
        end
        else if (cmd.conv_step)
        begin
            bcd_next    = {bcd_adj[BCD_W-2:0], mag_reg[MAG_W-1]};
            mag_next    = {mag_reg[MAG_W-2:0], 1'b0};
            bitcnt_next = bitcnt_reg + 1'b1;
        end
        else if (cmd.skip_step || cmd.emit_digit)
        begin
            bcd_next         = {bcd_reg[BCD_W-5:0], 4'd0};
            digits_left_next = digits_left_reg - 1'b1;
        end
    end

    // Output register, freed when the downstream side takes the transaction
    always_comb
    begin
        out_valid_next = out_valid_reg;
        char_code_next = char_code_reg;
        is_last_next   = is_last_reg;
        if (cmd.emit_sign)
        begin
            out_valid_next = 1'b1;
            char_code_next = CHAR_MINUS;
            is_last_next   = 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            out_valid_next = 1'b1;
            char_code_next = CHAR_ZERO + {2'b00, top_digit};
            is_last_next   = (digits_left_reg == DIGCNT_W'(1));
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            bitcnt_reg      <= '0;
            digits_left_reg <= '0;
        end
        else
        begin
            out_valid_reg   <= out_valid_next;
            bitcnt_reg      <= bitcnt_next;
            digits_left_reg <= digits_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg       <= mag_next;
        bcd_reg       <= bcd_next;
        neg_reg       <= neg_next;
        char_code_reg <= char_code_next;
        is_last_reg   <= is_last_next;
    end

    // Status back to the controller
    assign sts.conv_done  = (bitcnt_reg == BITCNT_W'(MAG_W - 1));
    assign sts.lead_zero  = (top_digit == 4'd0) && (digits_left_reg > DIGCNT_W'(1));
    assign sts.negative   = neg_reg;
    assign sts.last_digit = (digits_left_reg == DIGCNT_W'(1));
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign char_code = char_code_reg;
    assign is_last   = is_last_reg;

    // A held character is a minus sign or a decimal digit
    `ASSERT_HOLDS(a_char_range, clk, rst_n, out_valid_reg,
        (char_code_reg == CHAR_MINUS) ||
        ((char_code_reg >= CHAR_ZERO) && (char_code_reg <= CHAR_NINE)),
        "itoa_dp: character outside minus and digit codes")
    // Leading-zero skip never drops the units digit
    `ASSERT_HOLDS(a_skip_keeps_digit, clk, rst_n, cmd.skip_step,
        digits_left_reg > DIGCNT_W'(1), "itoa_dp: skip with one digit left")
    // The final digit is flagged as last
    `ASSERT_NEXT(a_last_flag, clk, rst_n, cmd.emit_digit && sts.last_digit,
        out_valid_reg && is_last_reg, "itoa_dp: final digit not flagged")

endmodule

>>> rtl/core/itoa_ctrl.sv
`include "assert_macros.svh"

module itoa_ctrl
    import itoa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  itoa_sts_t sts,
    output itoa_cmd_t cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CONV = 5'b00010,
        S_SKIP = 5'b00100,
        S_SIGN = 5'b01000,
        S_EMIT = 5'b10000
    } itoa_state_t;

    itoa_state_t state_reg, state_next;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                cmd.conv_step = 1'b1;
                if (sts.conv_done)
                begin
                    state_next = S_SKIP;
                end
            end
            S_SKIP:
            begin
                if (sts.lead_zero)
                begin
                    cmd.skip_step = 1'b1;
                end
                else
                begin
                    state_next = sts.negative ? S_SIGN : S_EMIT;
                end
            end
            S_SIGN:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (sts.last_digit)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // An accepted transaction always starts the conversion
    `ASSERT_NEXT(a_accept_starts, clk, rst_n, in_valid && in_ready,
        state_reg == S_CONV, "itoa_ctrl: accept did not start conversion")
    // Digits always follow the sign
    `ASSERT_NEXT(a_sign_then_digits, clk, rst_n, cmd.emit_sign,
        state_reg == S_EMIT, "itoa_ctrl: sign not followed by digits")

endmodule

>>> rtl/core/signed_int_to_decimal_ascii.sv
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_ready  value (signed 32)
// out      output     out_valid/out_ready  char_code (6), is_last (1)
//
// One number at a time: accept, shift-and-adjust over every magnitude bit,
// skip of each leading zero digit plus a final skip step, then emission
// of each character, the minus sign first when negative.
// The final character may wait in the output register while the next
// number is accepted; out_ready low stalls character emission.
// Reset clears the controller, the output valid flag and the bit and digit counters.

module signed_int_to_decimal_ascii
    import itoa_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [MAG_W-1:0] value,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [CHAR_W-1:0]       char_code,
    output logic                    is_last
);

    itoa_cmd_t cmd;
    itoa_sts_t sts;

    itoa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    itoa_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .char_code (char_code),
        .is_last   (is_last)
    );

endmodule

>>> verif/signed_int_to_decimal_ascii_test.sv
`timescale 1ns / 100ps

module signed_int_to_decimal_ascii_test
    import itoa_pkg::*;
();

    localparam int RADIX          = 10;
    localparam int RESET_CYCLES   = 9;
    localparam int ITEMS_PER_MODE = 80;
    localparam int DIR_ROWS       = 22;
    localparam int HOLD_CYCLES    = 300;
    localparam int QUIET_CYCLES   = 64;
    localparam int CYCLE_LIMIT    = 1000000;

    // One character of decimal text as it leaves the block
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } text_char_t;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic [MAG_W-1:0]  value     = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [CHAR_W-1:0] char_code;
    logic              is_last;

    // Characters still owed by the block, oldest first
    text_char_t pending_text[$];

    int fail_count    = 0;
    int cycle_count   = 0;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    // Directed numbers; text is typed in where it is obvious, else predicted
    logic [MAG_W-1:0] dir_values [DIR_ROWS] = '{
        32'd0,           32'd1,           -32'sd1,         32'd9,
        -32'sd9,         32'd10,          -32'sd10,        32'd99,
        32'd100,         32'd12345,       -32'sd678901,    32'd999999999,
        32'd1000000000,  -32'sd1000000000, 32'd1999999999, 32'd2147483647,
        -32'sd2147483647, 32'h8000_0000,  32'd1234567890,  -32'sd987654321,
        32'h5555_5555,   32'hAAAA_AAAA
    };
    string dir_text [DIR_ROWS] = '{
        "0",          "1",          "-1",         "9",
        "",           "10",         "",           "",
        "",           "",           "",           "",
        "1000000000", "",           "",           "2147483647",
        "",           "-2147483648", "",          "",
        "",           ""
    };

    signed_int_to_decimal_ascii dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .char_code (char_code),
        .is_last   (is_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void push_char(input logic [CHAR_W-1:0] code, input logic last);
        text_char_t c;
        c.code = code;
        c.last = last;
        pending_text.push_back(c);
    endfunction

    // Queue a hand-written expected string
    function automatic void expect_text(input string s);
        byte ch;
        for (int i = 0; i < s.len(); i++)
        begin
            ch = s[i];
            push_char(ch[CHAR_W-1:0], i == s.len() - 1);
        end
    endfunction

    // Decimal rendering of a 32-bit two's complement number
    function automatic void predict_text(input logic [MAG_W-1:0] raw);
        logic [MAG_W-1:0] mag;
        logic [3:0]       digit_buf [NUM_DIGITS];
        int               n;
        mag = raw[MAG_W-1] ? (~raw + 1'b1) : raw;
        digit_buf[0] = 4'(mag % RADIX);
        mag = mag / RADIX;
        n = 1;
        while (mag != 0 && n < NUM_DIGITS)
        begin
            digit_buf[n] = 4'(mag % RADIX);
            mag = mag / RADIX;
            n++;
        end
        if (raw[MAG_W-1])
            push_char(CHAR_MINUS, 1'b0);
        for (int k = n - 1; k >= 0; k--)
            push_char(CHAR_ZERO + {2'b00, digit_buf[k]}, k == 0);
    endfunction

    // Random number: a quarter raw bit patterns, the rest spread over digit counts
    function automatic logic [MAG_W-1:0] pick_number();
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mag;
        logic [MAG_W-1:0] r;
        int               digits;
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        digits = $urandom_range(1, NUM_DIGITS);
        lo = 1;
        repeat (digits - 1) lo = lo * RADIX;
        hi = lo * RADIX - 1;
        if (digits == 1)
            lo = 0;
        if (hi > 64'd2147483648)
            hi = 64'd2147483648;
        mag = lo + ({$urandom, $urandom} % (hi - lo + 1));
        r = mag[MAG_W-1:0];
        if ($urandom_range(0, 1) == 1)
            r = ~r + 1'b1;
        return r;
    endfunction

    // Idle cycles before the next input transaction
    function automatic int sender_gap();
        if (src_idle_pct == 0 || $urandom_range(0, 99) >= src_idle_pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(1, 60);
        return $urandom_range(1, 6);
    endfunction

    // Offer one number and hold it until the block takes it
    task automatic send_number(input logic [MAG_W-1:0] v, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Stop offering and wait until every owed character is out
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_text.size() != 0) @(posedge clk);
    endtask

    // Stimulus: directed table, then random numbers under three idling modes
    initial
    begin : stimulus
        logic [MAG_W-1:0] v;
        int               src_pct  [3] = '{36, 66, 0};
        int               sink_pct [3] = '{66, 36, 0};
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < DIR_ROWS; k++)
        begin
            send_number(dir_values[k], 0);
            if (dir_text[k].len() != 0)
                expect_text(dir_text[k]);
            else
                predict_text(dir_values[k]);
        end
        drain();

        for (int m = 0; m < 3; m++)
        begin
            src_idle_pct  = src_pct[m];
            sink_idle_pct = sink_pct[m];
            for (int i = 0; i < ITEMS_PER_MODE; i++)
            begin
                // long receiver stall while numbers keep coming
                if (m == 2 && i == 20)
                    hold_requests++;
                // sender pause until the output side is empty
                if (m == 1 && i == 40)
                    drain();
                v = pick_number();
                send_number(v, sender_gap());
                predict_text(v);
            end
            drain();
        end

        repeat (QUIET_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("signed_int_to_decimal_ascii regression: pass");
        else
            $display("signed_int_to_decimal_ascii regression: fail");
        $finish;
    end

    // Output side: check each accepted character, then pick next ready
    always @(posedge clk)
    begin : receiver
        text_char_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_text.size() == 0)
            begin
                $display("%0t: unexpected character: expected none, got code %0d last %0b",
                         $time, char_code, is_last);
                fail_count++;
            end
            else
            begin
                want = pending_text.pop_front();
                if (char_code !== want.code)
                begin
                    $display("%0t: char_code mismatch: expected %0d, got %0d",
                             $time, want.code, char_code);
                    fail_count++;
                end
                if (is_last !== want.last)
                begin
                    $display("%0t: is_last mismatch: expected %0b, got %0b",
                             $time, want.last, is_last);
                    fail_count++;
                end
            end
        end

        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("signed_int_to_decimal_ascii regression: fail");
            $finish;
        end
    end

endmodule
